### rtl/ddgs_pkg.sv
package ddgs_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int ANGLE_BITS   = 16;
    localparam int ITER_W       = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam int Z_W          = ANGLE_BITS + 2;
    localparam int XY_W         = 28;
    localparam int ADDR_W       = 5;
    localparam int DATA_W       = 32;

    // bam16 conversion of the cordic angle
    localparam int SH_DN      = (ANGLE_BITS >= 16) ? (ANGLE_BITS - 16) : 0;
    localparam int SH_UP      = (ANGLE_BITS < 16) ? (16 - ANGLE_BITS) : 0;
    localparam int ROUND_HALF = (1 << SH_DN) >> 1;

    localparam logic signed [15:0] EIGHTH_TURN  = 16'sd8192;
    localparam logic signed [15:0] REVERSE_EDGE = 16'sd24576;
    localparam logic [15:0]        PI_Q13       = 16'd25736;

    localparam logic [14:0] RST_REACH_DISTANCE = 15'd51;
    localparam logic [14:0] RST_REACH_ANGLE    = 15'd2086;
    localparam logic [14:0] RST_DRIVE_SPEED    = 15'd1280;
    localparam logic [14:0] RST_SPIN_OFFSET    = 15'd26;
    localparam logic [15:0] RST_TIME_LIMIT     = 16'd10000;

    localparam logic [2:0] REG_REACH_DISTANCE = 3'd0;
    localparam logic [2:0] REG_REACH_ANGLE    = 3'd1;
    localparam logic [2:0] REG_DRIVE_SPEED    = 3'd2;
    localparam logic [2:0] REG_SPIN_OFFSET    = 3'd3;
    localparam logic [2:0] REG_TIME_LIMIT     = 3'd4;

    // atan(2^-i), full turn = 2^32
    localparam logic [31:0] ATAN_TURN32 [24] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    typedef struct packed {
        logic               mode_turn;
        logic               new_goal;
        logic signed [15:0] goal_x;
        logic signed [15:0] goal_y;
        logic signed [15:0] goal_heading;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] heading;
    } tick_t;

    typedef struct packed {
        logic signed [15:0] right_speed;
        logic signed [15:0] left_speed;
        logic               done_res;
        logic               timed_out;
    } steer_t;

    typedef struct packed {
        logic [14:0] reach_distance;
        logic [14:0] reach_angle;
        logic [14:0] drive_speed;
        logic [14:0] spin_offset;
        logic [15:0] time_limit_ticks;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_TURN_MUL,
        ST_TURN_RES,
        ST_SQ_DX,
        ST_SQ_DY,
        ST_SQ_R,
        ST_REACH,
        ST_CORDIC_INIT,
        ST_CORDIC,
        ST_ARC_MUL,
        ST_ARC_RES,
        ST_OUT
    } st_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_CHECK,
        DP_TURN_MUL,
        DP_TURN_RES,
        DP_SQ_DX,
        DP_SQ_DY,
        DP_SQ_R,
        DP_REACH,
        DP_CORDIC_INIT,
        DP_CORDIC_STEP,
        DP_ARC_MUL,
        DP_ARC_RES,
        DP_OUT_LOAD
    } dp_op_t;

    typedef enum logic [2:0] {
        ARC_FWD_RIGHT,
        ARC_FWD_LEFT,
        ARC_REV_RIGHT,
        ARC_REV_LEFT,
        ARC_SPIN_CW,
        ARC_SPIN_CCW
    } arc_t;

    typedef struct packed {
        logic tout;
        logic turn;
        logic reached;
        logic cordic_last;
    } dp_stat_t;

    function automatic logic [Z_W-1:0] atan_angle(input logic [ITER_W-1:0] i);
        logic [32:0] t;
        t = {1'b0, ATAN_TURN32[i]} + (33'd1 << (31 - ANGLE_BITS));
        return Z_W'(t >> (32 - ANGLE_BITS));
    endfunction

    function automatic logic signed [15:0] to_bam16(input logic [ANGLE_BITS-1:0] zm);
        logic [ANGLE_BITS+16:0] t;
        t = {17'd0, zm} + (ANGLE_BITS + 17)'(ROUND_HALF);
        t = (t >> SH_DN) << SH_UP;
        return t[15:0];
    endfunction

endpackage

### rtl/ddgs_regs.sv
module ddgs_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ddgs_pkg::ADDR_W-1:0] paddr,
    input  logic [ddgs_pkg::DATA_W-1:0] pwdata,
    output logic [ddgs_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output ddgs_pkg::cfg_t             cfg
);
    import ddgs_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[4:2];
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_REACH_DISTANCE: cfg_next.reach_distance   = pwdata[14:0];
                REG_REACH_ANGLE:    cfg_next.reach_angle      = pwdata[14:0];
                REG_DRIVE_SPEED:    cfg_next.drive_speed      = pwdata[14:0];
                REG_SPIN_OFFSET:    cfg_next.spin_offset      = pwdata[14:0];
                REG_TIME_LIMIT:     cfg_next.time_limit_ticks = pwdata[15:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_REACH_DISTANCE: prdata = {17'd0, cfg_reg.reach_distance};
            REG_REACH_ANGLE:    prdata = {17'd0, cfg_reg.reach_angle};
            REG_DRIVE_SPEED:    prdata = {17'd0, cfg_reg.drive_speed};
            REG_SPIN_OFFSET:    prdata = {17'd0, cfg_reg.spin_offset};
            REG_TIME_LIMIT:     prdata = {16'd0, cfg_reg.time_limit_ticks};
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reach_distance   <= RST_REACH_DISTANCE;
            cfg_reg.reach_angle      <= RST_REACH_ANGLE;
            cfg_reg.drive_speed      <= RST_DRIVE_SPEED;
            cfg_reg.spin_offset      <= RST_SPIN_OFFSET;
            cfg_reg.time_limit_ticks <= RST_TIME_LIMIT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### rtl/ddgs_ctrl.sv
module ddgs_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               tick_valid,
    output logic               tick_ready,
    output logic               steer_valid,
    input  logic               steer_ready,
    input  ddgs_pkg::dp_stat_t stat,
    output ddgs_pkg::dp_op_t   op
);
    import ddgs_pkg::*;

    st_t  state_reg;
    st_t  state_next;
    logic out_valid_reg;
    logic out_valid_next;

    assign steer_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        op             = DP_NOP;
        tick_ready     = 1'b0;
        out_valid_next = out_valid_reg & ~steer_ready;
        case (state_reg)
            ST_IDLE:
            begin
                tick_ready = 1'b1;
                if (tick_valid)
                begin
                    op         = DP_LOAD;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                op = DP_CHECK;
                if (stat.tout)
                    state_next = ST_OUT;
                else if (stat.turn)
                    state_next = ST_TURN_MUL;
                else
                    state_next = ST_SQ_DX;
            end
            ST_TURN_MUL:
            begin
                op         = DP_TURN_MUL;
                state_next = ST_TURN_RES;
            end
            ST_TURN_RES:
            begin
                op         = DP_TURN_RES;
                state_next = ST_OUT;
            end
            ST_SQ_DX:
            begin
                op         = DP_SQ_DX;
                state_next = ST_SQ_DY;
            end
            ST_SQ_DY:
            begin
                op         = DP_SQ_DY;
                state_next = ST_SQ_R;
            end
            ST_SQ_R:
            begin
                op         = DP_SQ_R;
                state_next = ST_REACH;
            end
            ST_REACH:
            begin
                op = DP_REACH;
                if (stat.reached)
                    state_next = ST_OUT;
                else
                    state_next = ST_CORDIC_INIT;
            end
            ST_CORDIC_INIT:
            begin
                op         = DP_CORDIC_INIT;
                state_next = ST_CORDIC;
            end
            ST_CORDIC:
            begin
                op = DP_CORDIC_STEP;
                if (stat.cordic_last)
                    state_next = ST_ARC_MUL;
            end
            ST_ARC_MUL:
            begin
                op         = DP_ARC_MUL;
                state_next = ST_ARC_RES;
            end
            ST_ARC_RES:
            begin
                op         = DP_ARC_RES;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // wait for the output slot to free up
                if (!out_valid_reg || steer_ready)
                begin
                    op             = DP_OUT_LOAD;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### rtl/ddgs_dp.sv
module ddgs_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  ddgs_pkg::dp_op_t   op,
    input  ddgs_pkg::tick_t    tick,
    input  ddgs_pkg::cfg_t     cfg,
    output ddgs_pkg::dp_stat_t stat,
    output ddgs_pkg::steer_t   steer
);
    import ddgs_pkg::*;

    // control state
    logic [15:0]            elapsed_reg;
    logic [15:0]            elapsed_next;
    logic                   tout_reg;
    logic                   tout_next;
    logic [ITER_W-1:0]      iter_reg;
    logic [ITER_W-1:0]      iter_next;

    // payload
    tick_t                  in_reg;
    tick_t                  in_next;
    logic [31:0]            prod_reg;
    logic [31:0]            prod_next;
    logic [32:0]            acc_reg;
    logic [32:0]            acc_next;
    logic signed [XY_W-1:0] x_reg;
    logic signed [XY_W-1:0] x_next;
    logic signed [XY_W-1:0] y_reg;
    logic signed [XY_W-1:0] y_next;
    logic [Z_W-1:0]         z_reg;
    logic [Z_W-1:0]         z_next;
    logic                   zero_reg;
    logic                   zero_next;
    arc_t                   arc_reg;
    arc_t                   arc_next;
    steer_t                 res_reg;
    steer_t                 res_next;
    steer_t                 out_reg;
    steer_t                 out_next;

    logic [15:0]            elapsed_eff;
    logic signed [16:0]     dx;
    logic signed [16:0]     dy;
    logic [15:0]            abs_dx;
    logic [15:0]            abs_dy;
    logic signed [15:0]     head_err;
    logic [15:0]            head_mag;
    logic [15:0]            mul_a;
    logic [15:0]            mul_b;
    logic [31:0]            mul_p;
    logic                   reached;
    logic [31:0]            turn_rnd;
    logic [16:0]            spin_sum;
    logic [14:0]            spin_sat;
    logic signed [15:0]     spin_spd;
    logic signed [XY_W-1:0] x_init;
    logic signed [XY_W-1:0] y_init;
    logic signed [XY_W-1:0] x_sh;
    logic signed [XY_W-1:0] y_sh;
    logic [Z_W-1:0]         step_ang;
    logic signed [15:0]     bearing;
    logic signed [15:0]     rel;
    arc_t                   arc_sel;
    logic [13:0]            arc_k;
    logic [31:0]            arc_rnd;
    logic signed [15:0]     arc_spd;
    logic signed [15:0]     full_spd;

    assign elapsed_eff = tick.new_goal ? 16'd0 : elapsed_reg;

    assign dx     = {in_reg.goal_x[15], in_reg.goal_x} - {in_reg.pos_x[15], in_reg.pos_x};
    assign dy     = {in_reg.goal_y[15], in_reg.goal_y} - {in_reg.pos_y[15], in_reg.pos_y};
    assign abs_dx = dx[16] ? 16'(-dx) : dx[15:0];
    assign abs_dy = dy[16] ? 16'(-dy) : dy[15:0];

    assign head_err = in_reg.heading - in_reg.goal_heading;
    assign head_mag = head_err[15] ? 16'(-head_err) : head_err;

    // one shared multiplier, product registered
    always_comb
    begin
        case (op)
            DP_TURN_MUL:
            begin
                mul_a = head_mag;
                mul_b = PI_Q13;
            end
            DP_SQ_DX:
            begin
                mul_a = abs_dx;
                mul_b = abs_dx;
            end
            DP_SQ_DY:
            begin
                mul_a = abs_dy;
                mul_b = abs_dy;
            end
            DP_SQ_R:
            begin
                mul_a = {1'b0, cfg.reach_distance};
                mul_b = {1'b0, cfg.reach_distance};
            end
            DP_ARC_MUL:
            begin
                mul_a = {1'b0, cfg.drive_speed};
                mul_b = {2'b0, arc_k};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p   = {16'd0, mul_a} * {16'd0, mul_b};
    assign reached = acc_reg < {1'b0, prod_reg};

    // turn speed: offset plus |err| * pi / 128, saturated
    assign turn_rnd = prod_reg + 32'd524288;
    assign spin_sum = {2'b0, cfg.spin_offset} + {5'b0, turn_rnd[31:20]};
    assign spin_sat = (spin_sum[16:15] != 2'b00) ? 15'h7fff : spin_sum[14:0];
    assign spin_spd = {1'b0, spin_sat};

    // cordic, one rotation per cycle
    assign x_init   = {{(XY_W - 25){dx[16]}}, dx, 8'd0};
    assign y_init   = {{(XY_W - 25){dy[16]}}, dy, 8'd0};
    assign x_sh     = x_reg >>> iter_reg;
    assign y_sh     = y_reg >>> iter_reg;
    assign step_ang = atan_angle(iter_reg);

    assign bearing = zero_reg ? 16'sd0 : to_bam16(z_reg[ANGLE_BITS-1:0]);
    assign rel     = in_reg.heading - bearing;

    always_comb
    begin
        if (rel >= 16'sd0 && rel <= EIGHTH_TURN)
        begin
            arc_sel = ARC_FWD_RIGHT;
            arc_k   = 14'(EIGHTH_TURN - rel);
        end
        else if (rel < 16'sd0 && rel >= -EIGHTH_TURN)
        begin
            arc_sel = ARC_FWD_LEFT;
            arc_k   = 14'(EIGHTH_TURN + rel);
        end
        else if (rel >= REVERSE_EDGE)
        begin
            arc_sel = ARC_REV_RIGHT;
            arc_k   = 14'(rel - REVERSE_EDGE);
        end
        else if (rel <= -REVERSE_EDGE)
        begin
            // wraps correctly for the most negative angle
            arc_sel = ARC_REV_LEFT;
            arc_k   = 14'(-rel - REVERSE_EDGE);
        end
        else if (rel > EIGHTH_TURN)
        begin
            arc_sel = ARC_SPIN_CW;
            arc_k   = '0;
        end
        else
        begin
            arc_sel = ARC_SPIN_CCW;
            arc_k   = '0;
        end
    end

    assign arc_rnd  = prod_reg + 32'd4096;
    assign arc_spd  = {1'b0, arc_rnd[27:13]};
    assign full_spd = {1'b0, cfg.drive_speed};

    always_comb
    begin
        elapsed_next = elapsed_reg;
        tout_next    = tout_reg;
        iter_next    = iter_reg;
        in_next      = in_reg;
        prod_next    = prod_reg;
        acc_next     = acc_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        z_next       = z_reg;
        zero_next    = zero_reg;
        arc_next     = arc_reg;
        res_next     = res_reg;
        out_next     = out_reg;
        case (op)
            DP_LOAD:
            begin
                in_next      = tick;
                tout_next    = elapsed_eff > cfg.time_limit_ticks;
                elapsed_next = (elapsed_eff == 16'hffff) ? elapsed_eff : elapsed_eff + 16'd1;
            end
            DP_CHECK:
            begin
                if (tout_reg)
                begin
                    res_next.right_speed = '0;
                    res_next.left_speed  = '0;
                    res_next.done_res    = 1'b1;
                    res_next.timed_out   = 1'b1;
                end
            end
            DP_TURN_MUL:
            begin
                prod_next = mul_p;
            end
            DP_TURN_RES:
            begin
                res_next.timed_out = 1'b0;
                if (head_mag < {1'b0, cfg.reach_angle})
                begin
                    res_next.right_speed = '0;
                    res_next.left_speed  = '0;
                    res_next.done_res    = 1'b1;
                end
                else
                begin
                    res_next.done_res = 1'b0;
                    if (!head_err[15] && head_err != 16'sd0)
                    begin
                        res_next.right_speed = -spin_spd;
                        res_next.left_speed  = spin_spd;
                    end
                    else
                    begin
                        res_next.right_speed = spin_spd;
                        res_next.left_speed  = -spin_spd;
                    end
                end
            end
            DP_SQ_DX:
            begin
                prod_next = mul_p;
            end
            DP_SQ_DY:
            begin
                acc_next  = {1'b0, prod_reg};
                prod_next = mul_p;
            end
            DP_SQ_R:
            begin
                acc_next  = acc_reg + {1'b0, prod_reg};
                prod_next = mul_p;
            end
            DP_REACH:
            begin
                if (reached)
                begin
                    res_next.right_speed = '0;
                    res_next.left_speed  = '0;
                    res_next.done_res    = 1'b1;
                    res_next.timed_out   = 1'b0;
                end
            end
            DP_CORDIC_INIT:
            begin
                iter_next = '0;
                zero_next = (dx == 17'sd0) && (dy == 17'sd0);
                if (dx[16])
                begin
                    // rotate into the right half plane
                    x_next = -x_init;
                    y_next = -y_init;
                    z_next = Z_W'(1) << (ANGLE_BITS - 1);
                end
                else
                begin
                    x_next = x_init;
                    y_next = y_init;
                    z_next = '0;
                end
            end
            DP_CORDIC_STEP:
            begin
                iter_next = iter_reg + ITER_W'(1);
                if (!y_reg[XY_W-1])
                begin
                    x_next = x_reg + y_sh;
                    y_next = y_reg - x_sh;
                    z_next = z_reg + step_ang;
                end
                else
                begin
                    x_next = x_reg - y_sh;
                    y_next = y_reg + x_sh;
                    z_next = z_reg - step_ang;
                end
            end
            DP_ARC_MUL:
            begin
                prod_next = mul_p;
                arc_next  = arc_sel;
            end
            DP_ARC_RES:
            begin
                res_next.done_res  = 1'b0;
                res_next.timed_out = 1'b0;
                case (arc_reg)
                    ARC_FWD_RIGHT:
                    begin
                        res_next.right_speed = arc_spd;
                        res_next.left_speed  = full_spd;
                    end
                    ARC_FWD_LEFT:
                    begin
                        res_next.right_speed = full_spd;
                        res_next.left_speed  = arc_spd;
                    end
                    ARC_REV_RIGHT:
                    begin
                        res_next.right_speed = -arc_spd;
                        res_next.left_speed  = -full_spd;
                    end
                    ARC_REV_LEFT:
                    begin
                        res_next.right_speed = -full_spd;
                        res_next.left_speed  = -arc_spd;
                    end
                    ARC_SPIN_CW:
                    begin
                        res_next.right_speed = -full_spd;
                        res_next.left_speed  = full_spd;
                    end
                    default:
                    begin
                        res_next.right_speed = full_spd;
                        res_next.left_speed  = -full_spd;
                    end
                endcase
            end
            DP_OUT_LOAD:
            begin
                out_next = res_reg;
            end
            default:
            begin
                prod_next = prod_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg <= '0;
            tout_reg    <= 1'b0;
            iter_reg    <= '0;
        end
        else
        begin
            elapsed_reg <= elapsed_next;
            tout_reg    <= tout_next;
            iter_reg    <= iter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg   <= in_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        zero_reg <= zero_next;
        arc_reg  <= arc_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

    assign stat.tout        = tout_reg;
    assign stat.turn        = in_reg.mode_turn;
    assign stat.reached     = reached;
    assign stat.cordic_last = (iter_reg == ITER_W'(CORDIC_STEPS - 1));
    assign steer            = out_reg;

endmodule

### rtl/diff_drive_goal_steering_top.sv
// differential-drive goal steering, one control tick per beat
//
// tick channel (tick_valid/tick_ready/tick) carries the pose and goal; the
// steer channel (steer_valid/steer_ready/steer) returns one beat per tick with
// both wheel speeds and the done / timed-out flags
// configuration goes through the apb port, one 32-bit register per word
// address; write only while no tick is in flight
//
// one tick at a time; states from tick accept to the output register:
//   time limit passed        check, out
//   turn mode                check, turn multiply, turn result, out
//   move mode, goal reached  check, square dx, square dy, square radius, reach, out
//   move mode, steering      up to reach, cordic init and loop, arc mul/res, out
// the 16-step cordic loop is the long pole; tick_ready rises in the cycle
// after the result moves into the output register
// the output register holds a finished beat while the receiver stalls, and
// the block still takes and works the next tick; it waits only if that one
// finishes before the held beat is taken
// reset clears the tick counter, loads the default registers and empties the
// output register
module diff_drive_goal_steering_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        tick_valid,
    output logic                        tick_ready,
    input  ddgs_pkg::tick_t             tick,
    output logic                        steer_valid,
    input  logic                        steer_ready,
    output ddgs_pkg::steer_t            steer,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ddgs_pkg::ADDR_W-1:0] paddr,
    input  logic [ddgs_pkg::DATA_W-1:0] pwdata,
    output logic [ddgs_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import ddgs_pkg::*;

    cfg_t     cfg;
    dp_op_t   op;
    dp_stat_t stat;

    ddgs_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ddgs_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .tick_valid  (tick_valid),
        .tick_ready  (tick_ready),
        .steer_valid (steer_valid),
        .steer_ready (steer_ready),
        .stat        (stat),
        .op          (op)
    );

    ddgs_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (op),
        .tick  (tick),
        .cfg   (cfg),
        .stat  (stat),
        .steer (steer)
    );

endmodule

### rtl/ddgs_checker.sv
module ddgs_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             tick_valid,
    input logic             tick_ready,
    input logic             steer_valid,
    input logic             steer_ready,
    input ddgs_pkg::steer_t steer
);
    import ddgs_pkg::*;

    // a held beat keeps its payload
    a_steer_hold: assert property (@(posedge clk) disable iff (!rst_n)
        steer_valid && !steer_ready |=> steer_valid && $stable(steer))
        else $error("steer beat changed while stalled");

    a_tout_done: assert property (@(posedge clk) disable iff (!rst_n)
        steer_valid && steer.timed_out |-> steer.done_res)
        else $error("timed_out without done_res");

    a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
        steer_valid && steer.done_res |-> steer.right_speed == 16'sd0
                                       && steer.left_speed == 16'sd0)
        else $error("nonzero speed on a done beat");

    // one tick in flight at a time
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        tick_valid && tick_ready |=> !tick_ready)
        else $error("tick taken while busy");

endmodule

bind diff_drive_goal_steering_top ddgs_checker u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .tick_valid  (tick_valid),
    .tick_ready  (tick_ready),
    .steer_valid (steer_valid),
    .steer_ready (steer_ready),
    .steer       (steer)
);

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import ddgs_pkg::*;

    localparam int CORDIC_PASSES   = 16;
    localparam int ARC_SPAN        = 8192;
    localparam int BACK_EDGE       = 24576;
    localparam int RAD_PER_BAM_Q20 = 25736;
    localparam int RANDOM_TICKS    = 1300;

    // atan(2^-i) as a share of a full turn, scaled by 2^32
    localparam logic [31:0] ATAN_STEP [CORDIC_PASSES] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861
    };

    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              tick_valid  = 1'b0;
    logic              tick_ready;
    tick_t             tick        = '0;
    logic              steer_valid;
    logic              steer_ready = 1'b0;
    steer_t            steer;
    logic              psel        = 1'b0;
    logic              penable     = 1'b0;
    logic              pwrite      = 1'b0;
    logic [ADDR_W-1:0] paddr       = '0;
    logic [DATA_W-1:0] pwdata      = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    // register shadows and the per-goal tick counter
    logic [14:0] lim_reach_dist = 15'd51;
    logic [14:0] lim_reach_ang  = 15'd2086;
    logic [14:0] spd_drive      = 15'd1280;
    logic [14:0] spd_spin       = 15'd26;
    logic [15:0] tick_budget    = 16'd10000;
    logic [15:0] goal_ticks     = 16'd0;

    steer_t steer_due[$];
    steer_t due_beat;
    int     sent_ticks     = 0;
    int     mismatch_count = 0;
    bit     calm_tx        = 1'b0;
    bit     calm_rx        = 1'b0;

    diff_drive_goal_steering_top u_top (.*);

    always #5 clk = ~clk;

    function automatic logic signed [15:0] bearing_to(input longint dx, input longint dy);
        longint x, y, z, a, xs, ys;
        int     i;
        if (dx == 0 && dy == 0)
            return 16'sd0;
        x = dx * 256;
        y = dy * 256;
        z = 0;
        // fold the left half plane onto the right one
        if (x < 0)
        begin
            x = -x;
            y = -y;
            z = 32768;
        end
        for (i = 0; i < CORDIC_PASSES; i++)
        begin
            a  = (longint'(ATAN_STEP[i]) + 32768) >>> 16;
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + a;
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - a;
            end
        end
        return z[15:0];
    endfunction

    function automatic longint arc_share(input longint k);
        return (longint'(spd_drive) * k + 4096) >>> 13;
    endfunction

    function automatic steer_t predict_steer(input tick_t t);
        steer_t             r;
        longint             dx, dy, d2, r2, s, bl, mag, sp;
        logic signed [15:0] b, err;
        r = '0;
        if (t.new_goal)
            goal_ticks = 16'd0;
        if (goal_ticks > tick_budget)
        begin
            r.done_res  = 1'b1;
            r.timed_out = 1'b1;
        end
        else if (!t.mode_turn)
        begin
            dx = longint'(t.goal_x) - longint'(t.pos_x);
            dy = longint'(t.goal_y) - longint'(t.pos_y);
            d2 = dx * dx + dy * dy;
            r2 = longint'(lim_reach_dist) * longint'(lim_reach_dist);
            if (d2 < r2)
                r.done_res = 1'b1;
            else
            begin
                b  = t.heading - bearing_to(dx, dy);
                bl = b;
                s  = spd_drive;
                if (bl >= 0 && bl <= ARC_SPAN)
                begin
                    r.right_speed = 16'(arc_share(ARC_SPAN - bl));
                    r.left_speed  = 16'(s);
                end
                else if (bl < 0 && bl >= -ARC_SPAN)
                begin
                    r.right_speed = 16'(s);
                    r.left_speed  = 16'(arc_share(ARC_SPAN + bl));
                end
                else if (bl >= BACK_EDGE)
                begin
                    r.right_speed = 16'(-arc_share(bl - BACK_EDGE));
                    r.left_speed  = 16'(-s);
                end
                else if (bl <= -BACK_EDGE)
                begin
                    r.right_speed = 16'(-s);
                    r.left_speed  = 16'(-arc_share(-bl - BACK_EDGE));
                end
                else if (bl > ARC_SPAN)
                begin
                    r.right_speed = 16'(-s);
                    r.left_speed  = 16'(s);
                end
                else
                begin
                    r.right_speed = 16'(s);
                    r.left_speed  = 16'(-s);
                end
            end
        end
        else
        begin
            err = t.heading - t.goal_heading;
            mag = (err < 0) ? -longint'(err) : longint'(err);
            if (mag < longint'(lim_reach_ang))
                r.done_res = 1'b1;
            else
            begin
                sp = longint'(spd_spin) + ((mag * RAD_PER_BAM_Q20 + 524288) >>> 20);
                if (sp > 32767)
                    sp = 32767;
                if (err > 0)
                begin
                    r.right_speed = 16'(-sp);
                    r.left_speed  = 16'(sp);
                end
                else
                begin
                    r.right_speed = 16'(sp);
                    r.left_speed  = 16'(-sp);
                end
            end
        end
        if (goal_ticks != 16'hFFFF)
            goal_ticks = goal_ticks + 16'd1;
        return r;
    endfunction

    function automatic tick_t mk_tick(input bit turn, input bit fresh,
                                      input int gx, input int gy, input int gh,
                                      input int px, input int py, input int hd);
        tick_t t;
        t.mode_turn    = turn;
        t.new_goal     = fresh;
        t.goal_x       = 16'(gx);
        t.goal_y       = 16'(gy);
        t.goal_heading = 16'(gh);
        t.pos_x        = 16'(px);
        t.pos_y        = 16'(py);
        t.heading      = 16'(hd);
        return t;
    endfunction

    function automatic int pick_level(input int low_span, input int top);
        case ($urandom_range(7))
            0: return 0;
            1: return top;
            2, 3: return $urandom_range(top);
            default: return $urandom_range(low_span);
        endcase
    endfunction

    task automatic report_mismatch(input string field, input longint got, input longint want);
        $display("%0t steer %s: got %0d, want %0d", $time, field, got, want);
        mismatch_count++;
    endtask

    task automatic send_tick(input tick_t t);
        tick_valid <= 1'b1;
        tick       <= t;
        do
            @(posedge clk);
        while (!tick_ready);
        steer_due.push_back(predict_steer(t));
        sent_ticks++;
        if (!calm_tx && $urandom_range(99) < 11)
        begin
            tick_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < 40);
        end
    endtask

    // stop sending and let every pending beat come back
    task automatic drain();
        tick_valid <= 1'b0;
        while (steer_due.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // bus goes idle between transfers
        @(posedge clk);
        case (idx)
            REG_REACH_DISTANCE: lim_reach_dist = value[14:0];
            REG_REACH_ANGLE:    lim_reach_ang  = value[14:0];
            REG_DRIVE_SPEED:    spd_drive      = value[14:0];
            REG_SPIN_OFFSET:    spd_spin       = value[14:0];
            REG_TIME_LIMIT:     tick_budget    = value[15:0];
            default: ;
        endcase
    endtask

    task automatic load_defaults();
        write_reg(REG_REACH_DISTANCE, 32'd51);
        write_reg(REG_REACH_ANGLE, 32'd2086);
        write_reg(REG_DRIVE_SPEED, 32'd1280);
        write_reg(REG_SPIN_OFFSET, 32'd26);
        write_reg(REG_TIME_LIMIT, 32'd10000);
    endtask

    task automatic test_default_steering();
        // forward arc, both edges, spin and reverse zones
        send_tick(mk_tick(0, 1, 1000, 0, 0, 0, 0, 0));
        send_tick(mk_tick(0, 0, 1000, 0, 0, 0, 0, 4096));
        send_tick(mk_tick(0, 0, 1000, 0, 0, 0, 0, -8192));
        send_tick(mk_tick(0, 0, 1000, 0, 0, 0, 0, 8192));
        send_tick(mk_tick(0, 0, 1000, 0, 0, 0, 0, 16384));
        send_tick(mk_tick(0, 0, 1000, 0, 0, 0, 0, -16384));
        send_tick(mk_tick(0, 0, 1000, 0, 0, 0, 0, 24576));
        send_tick(mk_tick(0, 0, 1000, 0, 0, 0, 0, -32768));
        send_tick(mk_tick(0, 0, 1000, 0, 0, 0, 0, 28000));
        // largest differences, and goals behind on the x axis
        send_tick(mk_tick(0, 0, 32767, 32767, 0, -32768, -32768, 0));
        send_tick(mk_tick(0, 0, -32768, -32768, 0, 32767, 32767, 32767));
        send_tick(mk_tick(0, 0, -32768, 0, 0, 0, 0, 0));
        send_tick(mk_tick(0, 0, 10, 10, 0, 0, 0, 0));
        // turn mode: both directions, half-turn error, wrap, tolerance edge
        send_tick(mk_tick(1, 0, 0, 0, 0, 0, 0, 10000));
        send_tick(mk_tick(1, 0, 0, 0, 0, 0, 0, -32768));
        send_tick(mk_tick(1, 0, 0, 0, -32768, 0, 0, 32767));
        send_tick(mk_tick(1, 0, 0, 0, 2086, 0, 0, 0));
    endtask

    task automatic test_register_extremes();
        drain();
        write_reg(REG_REACH_DISTANCE, 32'd0);
        write_reg(REG_REACH_ANGLE, 32'd0);
        write_reg(REG_DRIVE_SPEED, 32'd32767);
        write_reg(REG_SPIN_OFFSET, 32'd32767);
        write_reg(REG_TIME_LIMIT, 32'd65535);
        // goal on top of the robot gives a zero bearing
        send_tick(mk_tick(0, 1, 500, -700, 0, 500, -700, 1000));
        send_tick(mk_tick(0, 0, 0, -300, 0, 0, 0, 0));
        send_tick(mk_tick(1, 0, 0, 0, 1234, 0, 0, 1234));
        send_tick(mk_tick(1, 0, 0, 0, 0, 0, 0, 5));
        drain();
        write_reg(REG_REACH_DISTANCE, 32'd32767);
        write_reg(REG_REACH_ANGLE, 32'd32767);
        write_reg(REG_DRIVE_SPEED, 32'd0);
        write_reg(REG_SPIN_OFFSET, 32'd0);
        send_tick(mk_tick(0, 0, 32767, 32767, 0, -32768, -32768, 0));
        send_tick(mk_tick(0, 0, 100, 100, 0, 0, 0, 0));
        send_tick(mk_tick(1, 0, 0, 0, 0, 0, 0, -32768));
        send_tick(mk_tick(1, 0, 0, 0, 0, 0, 0, 100));
        drain();
        load_defaults();
    endtask

    task automatic test_tick_budget();
        int n;
        drain();
        write_reg(REG_TIME_LIMIT, 32'd0);
        send_tick(mk_tick(0, 1, 3000, 3000, 0, 0, 0, 0));
        send_tick(mk_tick(0, 0, 3000, 3000, 0, 0, 0, 0));
        // time limit wins over a reached goal
        send_tick(mk_tick(1, 0, 0, 0, 0, 0, 0, 0));
        send_tick(mk_tick(1, 1, 0, 0, 0, 0, 0, 0));
        drain();
        write_reg(REG_TIME_LIMIT, 32'd2);
        for (n = 0; n < 5; n++)
            send_tick(mk_tick(1, n == 0, 0, 0, 0, 0, 0, 9000));
        drain();
        load_defaults();
    endtask

    task automatic run_goal(input int len);
        tick_t        t;
        logic [127:0] noise;
        int           spread;
        int           n;
        t.mode_turn    = ($urandom_range(2) == 0);
        t.new_goal     = 1'b0;
        t.goal_x       = 16'($urandom);
        t.goal_y       = 16'($urandom);
        t.goal_heading = 16'($urandom);
        t.pos_x        = 16'($urandom);
        t.pos_y        = 16'($urandom);
        t.heading      = 16'($urandom);
        case ($urandom_range(2))
            0: spread = 64;
            1: spread = 2048;
            default: spread = 32768;
        endcase
        for (n = 0; n < len; n++)
        begin
            t.new_goal = (n == 0) ? ($urandom_range(9) != 0) : ($urandom_range(39) == 0);
            t.pos_x    = t.goal_x + 16'(int'($urandom_range(2 * spread)) - spread);
            t.pos_y    = t.goal_y + 16'(int'($urandom_range(2 * spread)) - spread);
            if (t.mode_turn)
                t.heading = t.goal_heading + 16'(int'($urandom_range(2 * spread)) - spread);
            else
                t.heading = t.heading + 16'(int'($urandom_range(4096)) - 2048);
            if ($urandom_range(9) == 0)
            begin
                noise = {$urandom, $urandom, $urandom, $urandom};
                send_tick(noise[$bits(tick_t)-1:0]);
            end
            else
                send_tick(t);
            // close in on the goal tick by tick
            spread = spread * 3 / 4;
        end
    endtask

    task automatic test_random_goals();
        int first;
        int phase_end;
        int phase;
        first = sent_ticks;
        phase = 0;
        while (sent_ticks - first < RANDOM_TICKS)
        begin
            drain();
            // upper bits are junk and must be ignored
            write_reg(REG_REACH_DISTANCE, ($urandom << 15) | pick_level(96, 32767));
            write_reg(REG_REACH_ANGLE, ($urandom << 15) | pick_level(4096, 32767));
            write_reg(REG_DRIVE_SPEED, ($urandom << 15) | pick_level(2048, 32767));
            write_reg(REG_SPIN_OFFSET, ($urandom << 15) | pick_level(512, 32767));
            write_reg(REG_TIME_LIMIT, ($urandom << 16) | pick_level(40, 65535));
            calm_tx   = (phase == 2);
            calm_rx   = (phase == 2);
            phase_end = sent_ticks + $urandom_range(80, 160);
            while (sent_ticks < phase_end)
                run_goal($urandom_range(1, 24));
            phase++;
        end
        calm_tx = 1'b0;
        calm_rx = 1'b0;
    endtask

    always @(posedge clk)
        steer_ready <= calm_rx || ($urandom_range(99) >= 11);

    always @(posedge clk)
    begin
        if (rst_n && steer_valid && steer_ready)
        begin
            if (steer_due.size() == 0)
                report_mismatch("beat with nothing pending", 0, 0);
            else
            begin
                due_beat = steer_due.pop_front();
                if (steer.right_speed !== due_beat.right_speed)
                    report_mismatch("right_speed", steer.right_speed, due_beat.right_speed);
                if (steer.left_speed !== due_beat.left_speed)
                    report_mismatch("left_speed", steer.left_speed, due_beat.left_speed);
                if (steer.done_res !== due_beat.done_res)
                    report_mismatch("done_res", steer.done_res, due_beat.done_res);
                if (steer.timed_out !== due_beat.timed_out)
                    report_mismatch("timed_out", steer.timed_out, due_beat.timed_out);
            end
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_steering();
        test_register_extremes();
        test_tick_budget();
        test_random_goals();
        drain();
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

### sim.f
rtl/ddgs_pkg.sv
rtl/ddgs_regs.sv
rtl/ddgs_ctrl.sv
rtl/ddgs_dp.sv
rtl/diff_drive_goal_steering_top.sv
rtl/ddgs_checker.sv
tb/tb_top.sv
